>>> src/device_allowlist_match_table_assert.svh
// Assertion macros for the device allowlist match table checker.
// Depends on nothing; the user supplies the clock and reset names.
`ifndef DEVICE_ALLOWLIST_MATCH_TABLE_ASSERT_SVH
`define DEVICE_ALLOWLIST_MATCH_TABLE_ASSERT_SVH

// same-cycle implication
`define DALM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allowlist table check failed");

// next-cycle implication
`define DALM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allowlist table check failed");

`endif

>>> src/dalm_pkg.sv
// Shared types and constants for the device allowlist match table.
// No dependencies.
package dalm_pkg;

   localparam int MAX_ENTRIES   = 256;
   localparam int IDX_W         = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W         = $clog2(MAX_ENTRIES + 1);
   localparam int ID_W          = 16;
   localparam int ENTRY_COUNT_W = 9;

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_FIND,
      ST_SHIFT
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0] vendor;
      logic [ID_W-1:0] product;
      logic [ID_W-1:0] cls;
   } entry_type;

   typedef struct packed {
      logic pair_hit;
      logic class_hit;
   } match_type;

endpackage

>>> src/device_allowlist_match_table.sv
// Device allowlist match table: top level with the command sequencer.
// Depends on dalm_pkg, dalm_entry_ram, dalm_match_unit.
// Add and clear answer straight from idle; lookup scans with one RAM read per entry;
// remove scans newest to oldest, then shifts the later entries down over the gap.
// Throughput: one transaction at a time; busy is high until the result strobe,
// and a new start is taken in the strobe cycle. The receiver cannot stall.
// Reset (synchronous): empties the table; RAM contents are not cleared.
module device_allowlist_match_table
   import dalm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_command,
   input  logic [ID_W-1:0]          req_vendor_id,
   input  logic [ID_W-1:0]          req_product_id,
   input  logic [ID_W-1:0]          req_device_class,
   output logic                     rsp_strobe,
   output logic                     rsp_status,
   output logic                     rsp_allowed,
   output logic [ENTRY_COUNT_W-1:0] rsp_entry_count
);

   // control state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;   // entries held, packed at 0..count-1
   logic [CNT_W-1:0] ptr_ff, ptr_in;       // scan position
   logic             dv_ff, dv_in;         // RAM read data valid this cycle
   logic             rsp_valid_ff, rsp_valid_in;

   // payload
   entry_type        key_ff, key_in;
   logic             rsp_status_ff, rsp_status_in;
   logic             rsp_allowed_ff, rsp_allowed_in;

   // RAM port signals
   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   entry_type        wr_data, rd_data;
   match_type        hit;

   entry_type        req_entry;
   logic [CNT_W-1:0] ptr_nx1, ptr_nx2;
   cmd_type          cmd;

   assign req_entry = '{vendor: req_vendor_id, product: req_product_id,
                        cls: req_device_class};
   assign ptr_nx1   = ptr_ff + CNT_W'(1);
   assign ptr_nx2   = ptr_ff + CNT_W'(2);
   assign cmd       = cmd_type'(req_command);

   dalm_entry_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dalm_match_unit u_match (
      .entry (rd_data),
      .key   (key_ff),
      .hit   (hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_allowed_ff <= rsp_allowed_in;
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      ptr_in         = ptr_ff;
      dv_in          = 1'b0;
      key_in         = key_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_allowed_in = rsp_allowed_ff;
      wr_en          = 1'b0;
      wr_addr        = count_ff[IDX_W-1:0];
      wr_data        = req_entry;
      rd_en          = 1'b0;
      rd_addr        = ptr_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in         = req_entry;
               rsp_status_in  = 1'b0;
               rsp_allowed_in = 1'b0;
               case (cmd)
                  CMD_LOOKUP: begin
                     // scan oldest to newest
                     ptr_in   = '0;
                     state_in = ST_LOOKUP;
                  end
                  CMD_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= CNT_W'(MAX_ENTRIES)) begin
                        rsp_status_in = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_REMOVE: begin
                     // scan newest to oldest
                     ptr_in   = count_ff;
                     state_in = ST_FIND;
                  end
                  CMD_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         ST_LOOKUP: begin
            if (dv_ff && (hit.pair_hit || hit.class_hit)) begin
               rsp_allowed_in = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end else if (ptr_ff == count_ff) begin
               // all reads issued; finish once the last compare is done
               if (!dv_ff) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               rd_en  = 1'b1;
               ptr_in = ptr_nx1;
               dv_in  = 1'b1;
            end
         end

         ST_FIND: begin
            // when dv_ff is set, read data belongs to entry ptr_ff
            if (dv_ff && hit.pair_hit) begin
               if (ptr_nx1 == count_ff) begin
                  count_in     = count_ff - CNT_W'(1);
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = ptr_nx1[IDX_W-1:0];
                  dv_in    = 1'b1;
                  state_in = ST_SHIFT;
               end
            end else if (ptr_ff == '0) begin
               if (!dv_ff) begin
                  rsp_valid_in = 1'b1;   // miss still reports ok
                  state_in     = ST_IDLE;
               end
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff[IDX_W-1:0] - IDX_W'(1);
               ptr_in  = ptr_ff - CNT_W'(1);
               dv_in   = 1'b1;
            end
         end

         ST_SHIFT: begin
            // data of entry ptr+1 lands in entry ptr; next read runs two ahead
            if (dv_ff) begin
               wr_en   = 1'b1;
               wr_addr = ptr_ff[IDX_W-1:0];
               wr_data = rd_data;
               ptr_in  = ptr_nx1;
               if (ptr_nx2 < count_ff) begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_nx2[IDX_W-1:0];
                  dv_in   = 1'b1;
               end else begin
                  count_in     = count_ff - CNT_W'(1);
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_allowed     = rsp_allowed_ff;
   assign rsp_entry_count = ENTRY_COUNT_W'(count_ff);

endmodule

>>> src/dalm_entry_ram.sv
// Entry storage: one write port, one registered read port.
// Depends on dalm_pkg.
module dalm_entry_ram
   import dalm_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [MAX_ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/dalm_match_unit.sv
// Compares one stored entry against the transaction key.
// Depends on dalm_pkg.
module dalm_match_unit
   import dalm_pkg::*;
(
   input  entry_type entry,
   input  entry_type key,
   output match_type hit
);

   always_comb begin
      hit.pair_hit  = (entry.vendor == key.vendor) && (entry.product == key.product);
      // class zero in an entry never matches
      hit.class_hit = (entry.cls != '0) && (entry.cls == key.cls);
   end

endmodule

>>> src/dalm_checker.sv
// Port-level checks for the device allowlist match table, bound to the top.
// Depends on dalm_pkg and device_allowlist_match_table_assert.svh.
`include "device_allowlist_match_table_assert.svh"

module dalm_checker
   import dalm_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic [1:0]               req_command,
   input logic                     rsp_strobe,
   input logic                     rsp_status,
   input logic [ENTRY_COUNT_W-1:0] rsp_entry_count
);

   `DALM_ASSERT_NOW(a_no_rsp_while_busy, clock, reset, busy, !rsp_strobe)
   `DALM_ASSERT_NEXT(a_edit_answers_next, clock, reset, start && !busy && (req_command == CMD_ADD || req_command == CMD_CLEAR), rsp_strobe && !busy)
   `DALM_ASSERT_NOW(a_full_means_max, clock, reset, rsp_strobe && rsp_status, rsp_entry_count == ENTRY_COUNT_W'(MAX_ENTRIES))
   `DALM_ASSERT_NEXT(a_clear_empties, clock, reset, start && !busy && req_command == CMD_CLEAR, rsp_entry_count == '0)

endmodule

bind device_allowlist_match_table dalm_checker u_dalm_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_command     (req_command),
   .rsp_strobe      (rsp_strobe),
   .rsp_status      (rsp_status),
   .rsp_entry_count (rsp_entry_count)
);

>>> tb/tb_device_allowlist_match_table.sv
`timescale 1ns / 100ps
// Self-checking testbench for device_allowlist_match_table: directed, fill and random tests.
// Depends on dalm_pkg and the device_allowlist_match_table RTL; needs no other files.
module tb_device_allowlist_match_table;
   import dalm_pkg::*;

   // quiet cycles (no transaction accepted, no result) before the run is abandoned
   localparam int STALL_LIMIT = 20 * MAX_ENTRIES;
   // settle time after the last result; a lookup scans the whole table
   localparam int TAIL_CYCLES = MAX_ENTRIES + 16;
   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      logic                     status;
      logic                     allowed;
      logic [ENTRY_COUNT_W-1:0] count;
   } table_response_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [1:0]               req_command = CMD_LOOKUP;
   logic [ID_W-1:0]          req_vendor_id = '0;
   logic [ID_W-1:0]          req_product_id = '0;
   logic [ID_W-1:0]          req_device_class = '0;
   logic                     rsp_strobe;
   logic                     rsp_status;
   logic                     rsp_allowed;
   logic [ENTRY_COUNT_W-1:0] rsp_entry_count;

   // shadow copy of the allowlist, packed oldest first
   logic [ID_W-1:0] shadow_vendor  [MAX_ENTRIES];
   logic [ID_W-1:0] shadow_product [MAX_ENTRIES];
   logic [ID_W-1:0] shadow_class   [MAX_ENTRIES];
   int              shadow_count = 0;

   table_response_type pending_responses[$];
   table_response_type oldest_response;

   int sender_idle_pct = 0;
   int mismatch_count  = 0;
   int sent_count      = 0;
   int checked_count   = 0;
   int allowed_seen    = 0;
   int full_seen       = 0;
   int peak_count      = 0;
   int quiet_cycles    = 0;

   device_allowlist_match_table u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_vendor_id    (req_vendor_id),
      .req_product_id   (req_product_id),
      .req_device_class (req_device_class),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_allowed      (rsp_allowed),
      .rsp_entry_count  (rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Allowlist predictor: applies one transaction to the shadow table
   // and returns the response the block must give for it.
   // ---------------------------------------------------------------
   function automatic table_response_type apply_allowlist_command(
      cmd_type cmd, logic [ID_W-1:0] vendor, logic [ID_W-1:0] product,
      logic [ID_W-1:0] dev_class);
      table_response_type rsp;
      int                 i;
      int                 hit_pos;
      rsp = '0;
      hit_pos = -1;
      case (cmd)
         CMD_LOOKUP: begin
            // allowed on a vendor+product pair match, or a nonzero class match
            for (i = 0; i < shadow_count; i++) begin
               if (shadow_vendor[i] == vendor && shadow_product[i] == product)
                  rsp.allowed = 1'b1;
               if (shadow_class[i] != '0 && shadow_class[i] == dev_class)
                  rsp.allowed = 1'b1;
            end
         end
         CMD_ADD: begin
            if (shadow_count >= MAX_ENTRIES) begin
               rsp.status = 1'b1;               // full: table untouched
            end else begin
               shadow_vendor[shadow_count]  = vendor;
               shadow_product[shadow_count] = product;
               shadow_class[shadow_count]   = dev_class;
               shadow_count++;
            end
         end
         CMD_REMOVE: begin
            // newest match goes; a miss still answers ok
            for (i = shadow_count - 1; i >= 0; i--) begin
               if (hit_pos < 0 && shadow_vendor[i] == vendor && shadow_product[i] == product)
                  hit_pos = i;
            end
            if (hit_pos >= 0) begin
               for (i = hit_pos; i + 1 < shadow_count; i++) begin
                  shadow_vendor[i]  = shadow_vendor[i + 1];
                  shadow_product[i] = shadow_product[i + 1];
                  shadow_class[i]   = shadow_class[i + 1];
               end
               shadow_count--;
            end
         end
         default: begin
            shadow_count = 0;
         end
      endcase
      rsp.count = shadow_count[ENTRY_COUNT_W-1:0];
      return rsp;
   endfunction

   task automatic report_mismatch(string field, logic [15:0] want, logic [15:0] got);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t: mismatch on %s, result %0d: expected %h, got %h",
                  $time, field, checked_count, want, got);
   endtask

   // ---------------------------------------------------------------
   // Result checker and predictor hookup. The result strobed in this
   // cycle belongs to an older transaction, so it is checked before a
   // transaction accepted at the same edge is predicted.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_responses.size() == 0) begin
               report_mismatch("unexpected result", '0, {7'd0, rsp_entry_count});
            end else begin
               oldest_response = pending_responses.pop_front();
               if (rsp_status !== oldest_response.status)
                  report_mismatch("status", 16'(oldest_response.status), 16'(rsp_status));
               if (rsp_allowed !== oldest_response.allowed)
                  report_mismatch("allowed", 16'(oldest_response.allowed),
                                  16'(rsp_allowed));
               if (rsp_entry_count !== oldest_response.count)
                  report_mismatch("entry_count", 16'(oldest_response.count),
                                  16'(rsp_entry_count));
               if (oldest_response.allowed)
                  allowed_seen++;
               if (oldest_response.status)
                  full_seen++;
               checked_count++;
            end
         end
         if (start && !busy) begin
            pending_responses.push_back(apply_allowlist_command(cmd_type'(req_command),
               req_vendor_id, req_product_id, req_device_class));
            if (shadow_count > peak_count)
               peak_count = shadow_count;
         end
      end
   end

   // watchdog: a hang shows up as a long run of quiet cycles
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding",
                  $time, pending_responses.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------

   // one idle cycle; the fields carry junk while start is low
   task automatic idle_cycle();
      @(negedge clock);
      start            = 1'b0;
      req_command      = 2'($urandom_range(0, 3));
      req_vendor_id    = 16'($urandom);
      req_product_id   = 16'($urandom);
      req_device_class = 16'($urandom);
   endtask

   // drive one transaction and hold it until the block takes it
   task automatic send_transaction(cmd_type cmd, logic [ID_W-1:0] vendor,
                                   logic [ID_W-1:0] product, logic [ID_W-1:0] dev_class);
      while ($urandom_range(0, 99) < sender_idle_pct)
         idle_cycle();
      @(negedge clock);
      start            = 1'b1;
      req_command      = cmd;
      req_vendor_id    = vendor;
      req_product_id   = product;
      req_device_class = dev_class;
      do @(posedge clock); while (busy);
      sent_count++;
   endtask

   // hold off until every outstanding result has come back
   task automatic wait_for_results();
      @(negedge clock);
      start = 1'b0;
      while (pending_responses.size() != 0)
         @(negedge clock);
   endtask

   // ids drawn mostly from a small pool so lookups and removes hit often
   function automatic logic [ID_W-1:0] pooled_id();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h1D6B;
         3:       return 16'h8000;
         4:       return 16'h0001;
         5:       return 16'h2E8A;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [ID_W-1:0] pooled_class();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 16'h0000;
         4, 5:       return 16'h0003;
         6:          return 16'h00FF;
         7:          return 16'h8008;
         default:    return 16'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // field extremes, each command, and the corner cases of the table
   task automatic test_directed_cases();
      send_transaction(CMD_CLEAR,  16'h0000, 16'h0000, 16'h0000);  // clear when empty
      send_transaction(CMD_LOOKUP, 16'h0000, 16'h0000, 16'h0000);  // lookup on empty table
      send_transaction(CMD_REMOVE, 16'h0001, 16'h0002, 16'h0000);  // remove on empty table
      send_transaction(CMD_ADD,    16'h0000, 16'h0000, 16'h0000);
      send_transaction(CMD_ADD,    16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_transaction(CMD_LOOKUP, 16'h0000, 16'h0000, 16'h0000);  // pair hit, class zero
      send_transaction(CMD_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h0000);
      send_transaction(CMD_LOOKUP, 16'h1234, 16'h5678, 16'hFFFF);  // class-only hit
      send_transaction(CMD_LOOKUP, 16'h1234, 16'h5678, 16'h0000);  // zero class never hits
      send_transaction(CMD_LOOKUP, 16'h0000, 16'hFFFF, 16'h0000);  // half a pair is a miss
      send_transaction(CMD_ADD,    16'h0BAD, 16'h0001, 16'h0007);
      send_transaction(CMD_ADD,    16'h0BAD, 16'h0001, 16'h0009);  // duplicate pair
      send_transaction(CMD_ADD,    16'h0C0C, 16'h0002, 16'h0000);
      send_transaction(CMD_REMOVE, 16'h0BAD, 16'h0001, 16'hFFFF);  // newest duplicate goes
      send_transaction(CMD_LOOKUP, 16'h0000, 16'h0001, 16'h0009);
      send_transaction(CMD_LOOKUP, 16'h0000, 16'h0001, 16'h0007);
      send_transaction(CMD_REMOVE, 16'h0BAD, 16'h0001, 16'h0000);
      send_transaction(CMD_LOOKUP, 16'h0BAD, 16'h0001, 16'h0000);
      send_transaction(CMD_REMOVE, 16'h0000, 16'h0000, 16'h0000);  // oldest goes, gap closes
      send_transaction(CMD_LOOKUP, 16'h0C0C, 16'h0002, 16'h0000);
      send_transaction(CMD_REMOVE, 16'h7777, 16'h7777, 16'h0000);  // miss still ok
      send_transaction(CMD_CLEAR,  16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_transaction(CMD_CLEAR,  16'h0000, 16'h0000, 16'h0000);
      send_transaction(CMD_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
   endtask

   // fill the table to capacity, overflow it, then shift the whole table
   task automatic test_fill_to_capacity();
      int              i;
      logic [ID_W-1:0] last_vendor;
      logic [ID_W-1:0] last_product;
      send_transaction(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000);
      send_transaction(CMD_ADD, 16'hA5A5, 16'h5A5A, 16'h0000);
      for (i = 1; i < MAX_ENTRIES; i++)
         send_transaction(CMD_ADD, 16'($urandom), 16'($urandom), pooled_class());
      send_transaction(CMD_ADD, 16'h1111, 16'h2222, 16'h0003);      // table full
      send_transaction(CMD_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      wait_for_results();
      last_vendor  = shadow_vendor[MAX_ENTRIES - 1];
      last_product = shadow_product[MAX_ENTRIES - 1];
      send_transaction(CMD_LOOKUP, last_vendor, last_product, 16'h0000);
      send_transaction(CMD_LOOKUP, 16'hA5A5, 16'h5A5A, 16'h0000);
      send_transaction(CMD_LOOKUP, 16'h1111, 16'h2222, 16'h0000);  // overflowed entry is absent
      send_transaction(CMD_REMOVE, 16'hA5A5, 16'h5A5A, 16'h0000);  // longest shift
      send_transaction(CMD_LOOKUP, 16'hA5A5, 16'h5A5A, 16'h0000);
      send_transaction(CMD_ADD, 16'h4321, 16'h8765, 16'h00FF);
      send_transaction(CMD_ADD, 16'h0000, 16'h0000, 16'h0000);      // full again
      send_transaction(CMD_LOOKUP, 16'h4321, 16'h8765, 16'h0000);
      send_transaction(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000);
   endtask

   // random mix of commands on pooled ids; removes and lookups often
   // target entries that are really in the table
   task automatic test_random_traffic(int num_items, int idle_pct);
      int              n;
      int              pick;
      int              pos;
      cmd_type         cmd;
      logic [ID_W-1:0] vendor;
      logic [ID_W-1:0] product;
      sender_idle_pct = idle_pct;
      for (n = 0; n < num_items; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35)
            cmd = CMD_LOOKUP;
         else if (pick < 75)
            cmd = CMD_ADD;
         else if (pick < 95)
            cmd = CMD_REMOVE;
         else
            cmd = CMD_CLEAR;
         vendor  = pooled_id();
         product = pooled_id();
         if (cmd != CMD_ADD && shadow_count > 0 && $urandom_range(0, 1)) begin
            pos     = $urandom_range(0, shadow_count - 1);
            vendor  = shadow_vendor[pos];
            product = shadow_product[pos];
         end
         send_transaction(cmd, vendor, product, pooled_class());
      end
   endtask

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      sender_idle_pct = 30;
      test_directed_cases();
      wait_for_results();

      sender_idle_pct = 0;
      test_fill_to_capacity();
      wait_for_results();

      test_random_traffic(80, 30);
      wait_for_results();
      test_random_traffic(80, 69);
      wait_for_results();
      test_random_traffic(80, 0);
      wait_for_results();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_responses.size() != 0)
         report_mismatch("missing results", '0, 16'(pending_responses.size()));

      $display("Ran %0d transactions and checked %0d results; table peaked at %0d entries.",
               sent_count, checked_count, peak_count);
      $display("%0d lookups allowed, %0d adds refused on a full table, %0d mismatches.",
               allowed_seen, full_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+src
src/dalm_pkg.sv
src/dalm_entry_ram.sv
src/dalm_match_unit.sv
src/device_allowlist_match_table.sv
src/dalm_checker.sv
tb/tb_device_allowlist_match_table.sv
